// ----- hw/rtl/point_segment_distance_defines.svh -----
// assertion macros for the point to segment distance block
`ifndef POINT_SEGMENT_DISTANCE_DEFINES_SVH
`define POINT_SEGMENT_DISTANCE_DEFINES_SVH

// same-cycle implication, checked out of reset
`define PSD_ASSERT_IMP(lbl, ante, cons, msg) \
lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
	else $error(msg);

// next-cycle implication, checked out of reset
`define PSD_ASSERT_NXT(lbl, ante, cons, msg) \
lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
	else $error(msg);

`endif

// ----- hw/rtl/psd_pkg.sv -----
// shared types and constants for the point to segment distance block
package psd_pkg;

	localparam int COORD_BITS = 16;
	localparam int DIST_BITS  = 17;
	localparam int T_FRAC     = 16;

	localparam logic [DIST_BITS-1:0] DIST_MAX = 17'h1FFFF;
	localparam logic [T_FRAC:0]      T_ONE    = {1'b1, {T_FRAC{1'b0}}};

	typedef struct packed {
		logic signed [COORD_BITS-1:0] point_x;
		logic signed [COORD_BITS-1:0] point_y;
		logic signed [COORD_BITS-1:0] start_x;
		logic signed [COORD_BITS-1:0] start_y;
		logic signed [COORD_BITS-1:0] end_x;
		logic signed [COORD_BITS-1:0] end_y;
	} psd_in_t;

	typedef struct packed {
		logic [DIST_BITS-1:0] seg_distance;
		logic                 segment_degenerate;
	} psd_out_t;

	typedef struct packed {
		logic zero;
		logic one;
	} psd_clamp_t;

endpackage

// ----- hw/rtl/psd_div.sv -----
// pipelined restoring divider for the projection parameter, one quotient bit per stage
module psd_div import psd_pkg::*; #(
	parameter int L_W   = 2 * COORD_BITS + 1,
	parameter int TAG_W = 4 * (COORD_BITS + 1) + 1
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_vld,
	input  logic [L_W-1:0]   l2,
	input  logic [L_W-1:0]   rem,
	input  psd_clamp_t       clamp,
	input  logic [TAG_W-1:0] tag,
	output logic             out_vld,
	output logic [T_FRAC:0]  t,
	output logic [TAG_W-1:0] out_tag
);

	logic             vld_s   [1:T_FRAC];
	logic [L_W-1:0]   l2_s    [1:T_FRAC];
	logic [L_W-1:0]   rem_s   [1:T_FRAC];
	logic [T_FRAC-1:0] q_s    [1:T_FRAC];
	psd_clamp_t       clamp_s [1:T_FRAC];
	logic [TAG_W-1:0] tag_s   [1:T_FRAC];

	for (genvar k = 0; k < T_FRAC; k++) begin : g_step
		logic             vld_c;
		logic [L_W-1:0]   l2_c;
		logic [L_W-1:0]   rem_c;
		logic [T_FRAC-1:0] q_c;
		psd_clamp_t       clamp_c;
		logic [TAG_W-1:0] tag_c;
		logic [L_W:0]     shl;
		logic [L_W:0]     dif;
		logic             ge;

		if (k == 0) begin : g_first
			assign vld_c   = in_vld;
			assign l2_c    = l2;
			assign rem_c   = rem;
			assign q_c     = '0;
			assign clamp_c = clamp;
			assign tag_c   = tag;
		end else begin : g_next
			assign vld_c   = vld_s[k];
			assign l2_c    = l2_s[k];
			assign rem_c   = rem_s[k];
			assign q_c     = q_s[k];
			assign clamp_c = clamp_s[k];
			assign tag_c   = tag_s[k];
		end

		always_comb begin
			shl = {rem_c, 1'b0};
			dif = shl - {1'b0, l2_c};
			ge  = shl >= {1'b0, l2_c};
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[k+1] <= 1'b0;
			end else begin
				vld_s[k+1] <= vld_c;
			end
		end

		always_ff @(posedge clk) begin
			l2_s[k+1]    <= l2_c;
			rem_s[k+1]   <= ge ? dif[L_W-1:0] : shl[L_W-1:0];
			q_s[k+1]     <= {q_c[T_FRAC-2:0], ge};
			clamp_s[k+1] <= clamp_c;
			tag_s[k+1]   <= tag_c;
		end
	end

	assign out_vld = vld_s[T_FRAC];
	assign out_tag = tag_s[T_FRAC];

	always_comb begin
		priority if (clamp_s[T_FRAC].zero) begin
			t = '0;
		end else if (clamp_s[T_FRAC].one) begin
			t = T_ONE;
		end else begin
			t = {1'b0, q_s[T_FRAC]};
		end
	end

endmodule

// ----- hw/rtl/psd_sqrt.sv -----
// pipelined integer square root, one root bit per stage, floored
module psd_sqrt import psd_pkg::*; #(
	parameter int N_W   = 2 * (COORD_BITS + 2) + 1,
	parameter int TAG_W = 1,
	parameter int R_W   = (N_W + 1) / 2
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_vld,
	input  logic [N_W-1:0]   radicand,
	input  logic [TAG_W-1:0] tag,
	output logic             out_vld,
	output logic [R_W-1:0]   root,
	output logic [TAG_W-1:0] out_tag
);

	localparam int RAD_W = 2 * R_W;
	localparam int REM_W = R_W + 2;

	logic             vld_s  [1:R_W];
	logic [RAD_W-1:0] rad_s  [1:R_W];
	logic [REM_W-1:0] rem_s  [1:R_W];
	logic [R_W-1:0]   root_s [1:R_W];
	logic [TAG_W-1:0] tag_s  [1:R_W];

	for (genvar k = 0; k < R_W; k++) begin : g_step
		logic             vld_c;
		logic [RAD_W-1:0] rad_c;
		logic [REM_W-1:0] rem_c;
		logic [R_W-1:0]   root_c;
		logic [TAG_W-1:0] tag_c;
		logic [REM_W-1:0] raw;
		logic [REM_W-1:0] trial;
		logic             ge;

		if (k == 0) begin : g_first
			assign vld_c  = in_vld;
			assign rad_c  = RAD_W'(radicand);
			assign rem_c  = '0;
			assign root_c = '0;
			assign tag_c  = tag;
		end else begin : g_next
			assign vld_c  = vld_s[k];
			assign rad_c  = rad_s[k];
			assign rem_c  = rem_s[k];
			assign root_c = root_s[k];
			assign tag_c  = tag_s[k];
		end

		// bring down the next two radicand bits and try root*4+1
		always_comb begin
			raw   = {rem_c[REM_W-3:0], rad_c[RAD_W-1 -: 2]};
			trial = {root_c, 2'b01};
			ge    = raw >= trial;
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[k+1] <= 1'b0;
			end else begin
				vld_s[k+1] <= vld_c;
			end
		end

		always_ff @(posedge clk) begin
			rad_s[k+1]  <= {rad_c[RAD_W-3:0], 2'b00};
			rem_s[k+1]  <= ge ? (raw - trial) : raw;
			root_s[k+1] <= {root_c[R_W-2:0], ge};
			tag_s[k+1]  <= tag_c;
		end
	end

	assign out_vld = vld_s[R_W];
	assign root    = root_s[R_W];
	assign out_tag = tag_s[R_W];

endmodule

// ----- hw/rtl/point_segment_distance.sv -----
// throughput: one beat per cycle, set by the 16-stage divider and (COORD_BITS + 3)-stage root pipelines
// busy is held low: every start is taken and every result leaves on its done strobe
// reset clears all pipeline valid bits and the output strobe; data registers are not reset
`include "point_segment_distance_defines.svh"
// top level: differences, products, projection divide, offset, squares, square root
module point_segment_distance import psd_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     start,
	output logic     busy,
	input  psd_in_t  query,
	output logic     done,
	output psd_out_t result
);

	localparam int C    = COORD_BITS;
	localparam int DW   = C + 1;
	localparam int PW   = 2 * DW;
	localparam int L    = 2 * C + 1;
	localparam int DOTW = 2 * C + 3;
	localparam int TAGW = 4 * DW + 1;
	localparam int MW   = T_FRAC + 1 + C;
	localparam int EXW  = C + 2;
	localparam int NW   = 2 * EXW + 1;
	localparam int RW   = (NW + 1) / 2;
	localparam int EW   = (RW > DIST_BITS) ? RW : DIST_BITS;
	localparam int LAT  = 3 + T_FRAC + 4 + RW + 1;

	assign busy = 1'b0;

	// stage 1: differences against the start point
	logic                 vld_s1;
	logic signed [DW-1:0] px_s1, py_s1, dx_s1, dy_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else begin
			vld_s1 <= start && !busy;
		end
	end

	always_ff @(posedge clk) begin
		px_s1 <= {query.point_x[C-1], query.point_x} - {query.start_x[C-1], query.start_x};
		py_s1 <= {query.point_y[C-1], query.point_y} - {query.start_y[C-1], query.start_y};
		dx_s1 <= {query.end_x[C-1], query.end_x} - {query.start_x[C-1], query.start_x};
		dy_s1 <= {query.end_y[C-1], query.end_y} - {query.start_y[C-1], query.start_y};
	end

	// stage 2: four products
	logic                 vld_s2;
	logic signed [PW-1:0] sqx_s2, sqy_s2, dotx_s2, doty_s2;
	logic signed [DW-1:0] px_s2, py_s2, dx_s2, dy_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s2 <= 1'b0;
		end else begin
			vld_s2 <= vld_s1;
		end
	end

	always_ff @(posedge clk) begin
		sqx_s2  <= dx_s1 * dx_s1;
		sqy_s2  <= dy_s1 * dy_s1;
		dotx_s2 <= px_s1 * dx_s1;
		doty_s2 <= py_s1 * dy_s1;
		px_s2   <= px_s1;
		py_s2   <= py_s1;
		dx_s2   <= dx_s1;
		dy_s2   <= dy_s1;
	end

	// stage 3: length squared, dot product, clamp decision
	logic [L-1:0]           l2_c;
	logic signed [DOTW-1:0] dot_c;
	logic                   vld_s3, degen_s3;
	logic [L-1:0]           l2_s3, rem_s3;
	psd_clamp_t             clamp_s3;
	logic signed [DW-1:0]   px_s3, py_s3, dx_s3, dy_s3;

	always_comb begin
		l2_c  = sqx_s2[L-1:0] + sqy_s2[L-1:0];
		dot_c = {dotx_s2[PW-1], dotx_s2} + {doty_s2[PW-1], doty_s2};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s3 <= 1'b0;
		end else begin
			vld_s3 <= vld_s2;
		end
	end

	always_ff @(posedge clk) begin
		l2_s3         <= l2_c;
		rem_s3        <= dot_c[L-1:0];
		degen_s3      <= (l2_c == '0);
		clamp_s3.zero <= (dot_c <= 0) || (l2_c == '0);
		clamp_s3.one  <= dot_c >= $signed({2'b00, l2_c});
		px_s3         <= px_s2;
		py_s3         <= py_s2;
		dx_s3         <= dx_s2;
		dy_s3         <= dy_s2;
	end

	// projection parameter
	logic                 vld_d;
	logic [T_FRAC:0]      t_d;
	logic [TAGW-1:0]      tag_d;
	logic                 degen_d;
	logic signed [DW-1:0] px_d, py_d, dx_d, dy_d;

	psd_div #(
		.L_W   (L),
		.TAG_W (TAGW)
	) u_div (
		.clk     (clk),
		.arst_n  (arst_n),
		.in_vld  (vld_s3),
		.l2      (l2_s3),
		.rem     (rem_s3),
		.clamp   (clamp_s3),
		.tag     ({degen_s3, px_s3, py_s3, dx_s3, dy_s3}),
		.out_vld (vld_d),
		.t       (t_d),
		.out_tag (tag_d)
	);

	assign {degen_d, px_d, py_d, dx_d, dy_d} = tag_d;

	// stage 4: t times |d| per axis
	logic [DW-1:0]        magx_c, magy_c;
	logic                 vld_s4, degen_s4, negx_s4, negy_s4;
	logic [MW-1:0]        prodx_s4, prody_s4;
	logic signed [DW-1:0] px_s4, py_s4;

	always_comb begin
		magx_c = dx_d[DW-1] ? -dx_d : dx_d;
		magy_c = dy_d[DW-1] ? -dy_d : dy_d;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s4 <= 1'b0;
		end else begin
			vld_s4 <= vld_d;
		end
	end

	always_ff @(posedge clk) begin
		prodx_s4 <= t_d * magx_c[C-1:0];
		prody_s4 <= t_d * magy_c[C-1:0];
		negx_s4  <= dx_d[DW-1];
		negy_s4  <= dy_d[DW-1];
		degen_s4 <= degen_d;
		px_s4    <= px_d;
		py_s4    <= py_d;
	end

	// stage 5: floored offset, error vector
	logic [MW:0]           offx_c, offy_c;
	logic signed [EXW-1:0] offsx_c, offsy_c;
	logic                  vld_s5, degen_s5;
	logic signed [EXW-1:0] ex_s5, ey_s5;

	always_comb begin
		// negative direction rounds the magnitude up so the offset floors
		offx_c  = {1'b0, prodx_s4} + (negx_s4 ? (MW+1)'({T_FRAC{1'b1}}) : '0);
		offy_c  = {1'b0, prody_s4} + (negy_s4 ? (MW+1)'({T_FRAC{1'b1}}) : '0);
		offsx_c = EXW'(offx_c[T_FRAC +: C]);
		offsy_c = EXW'(offy_c[T_FRAC +: C]);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s5 <= 1'b0;
		end else begin
			vld_s5 <= vld_s4;
		end
	end

	always_ff @(posedge clk) begin
		ex_s5    <= {px_s4[DW-1], px_s4} + (negx_s4 ? offsx_c : -offsx_c);
		ey_s5    <= {py_s4[DW-1], py_s4} + (negy_s4 ? offsy_c : -offsy_c);
		degen_s5 <= degen_s4;
	end

	// stage 6: squares
	logic                    vld_s6, degen_s6;
	logic signed [2*EXW-1:0] sqex_s6, sqey_s6;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s6 <= 1'b0;
		end else begin
			vld_s6 <= vld_s5;
		end
	end

	always_ff @(posedge clk) begin
		sqex_s6  <= ex_s5 * ex_s5;
		sqey_s6  <= ey_s5 * ey_s5;
		degen_s6 <= degen_s5;
	end

	// stage 7: distance squared
	logic          vld_s7, degen_s7;
	logic [NW-1:0] sum_s7;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s7 <= 1'b0;
		end else begin
			vld_s7 <= vld_s6;
		end
	end

	always_ff @(posedge clk) begin
		sum_s7   <= {1'b0, sqex_s6} + {1'b0, sqey_s6};
		degen_s7 <= degen_s6;
	end

	logic          vld_r, degen_r;
	logic [RW-1:0] root_r;
	logic [EW-1:0] root_ext;

	psd_sqrt #(
		.N_W   (NW),
		.TAG_W (1),
		.R_W   (RW)
	) u_sqrt (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_vld   (vld_s7),
		.radicand (sum_s7),
		.tag      (degen_s7),
		.out_vld  (vld_r),
		.root     (root_r),
		.out_tag  (degen_r)
	);

	assign root_ext = EW'(root_r);

	// output register with saturation
	logic     done_q;
	psd_out_t result_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= vld_r;
		end
	end

	always_ff @(posedge clk) begin
		result_q.seg_distance       <= (root_ext > EW'(DIST_MAX)) ? DIST_MAX
			: root_ext[DIST_BITS-1:0];
		result_q.segment_degenerate <= degen_r;
	end

	assign done   = done_q;
	assign result = result_q;

	`PSD_ASSERT_IMP(a_lat_fwd, start && !busy, ##LAT done, "accepted beat did not complete")
	`PSD_ASSERT_IMP(a_lat_back, done, $past(start, LAT), "done without a matching start")
	`PSD_ASSERT_IMP(a_degen_src, done && result.segment_degenerate, $past(query.start_x == query.end_x && query.start_y == query.end_y, LAT), "degenerate flag on a real segment")
	`PSD_ASSERT_NXT(a_degen_t, vld_d && degen_d, vld_s4 && prodx_s4 == '0 && prody_s4 == '0, "degenerate segment with nonzero offset")

endmodule
